// ===== sv/sti_pkg.sv =====
`default_nettype none
package sti_pkg;
    localparam int TableDepth = 1024;
    localparam int AddrW = $clog2(TableDepth);
    localparam int CountW = AddrW + 1;
    localparam int FracBits = 32;
    localparam int DayW = 49;
    localparam int ValW = 36;
    localparam int NumVals = 6;
    localparam int QDepth = 2;

    typedef enum logic [2:0] {
        M_CLEAR = 3'd0,
        M_APPEND = 3'd1,
        M_NEAREST = 3'd2,
        M_INTERP = 3'd3,
        M_RESOLVE = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK = 3'd0,
        ST_EMPTY = 3'd1,
        ST_RANGE = 3'd2,
        ST_FULL = 3'd3,
        ST_ORDER = 3'd4
    } t_status;

    typedef logic signed [ValW-1:0] t_val;
    typedef t_val t_vals [NumVals];

    // Command handed from the front to the back.
    typedef struct packed {
        logic [2:0] mode;
        logic [DayW-1:0] day;
        logic [NumVals*ValW-1:0] vals;
        logic pred;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_SEARCH,
        S_SWAIT,
        S_READA,
        S_READB,
        S_WAITB,
        S_PICK,
        S_DIV,
        S_MUL,
        S_MULW,
        S_OUT
    } t_state;
endpackage
`default_nettype wire

// ===== sv/sti_front.sv =====
`default_nettype none
module sti_front
    import sti_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic o_stall,
    input  wire t_cmd i_cmd,
    output logic o_valid,
    input  wire logic i_take,
    output t_cmd o_cmd
);
    t_cmd r_q [QDepth];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;

    assign o_stall = (r_cnt == 2'(QDepth));
    assign push = i_valid && !o_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign pop = o_valid && i_take;
    assign o_cmd = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

// ===== sv/sti_back.sv =====
`default_nettype none
module sti_back
    import sti_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic o_take,
    input  wire t_cmd i_cmd,
    output logic o_valid,
    input  wire logic i_stall,
    output logic [2:0] o_status,
    output logic [DayW-1:0] o_day,
    output logic [NumVals*ValW-1:0] o_vals,
    output logic o_pred
);
    localparam int RecW = DayW + NumVals*ValW + 1;
    localparam int MagW = ValW + 1;
    localparam int LoW = 32;
    localparam int HiW = MagW - LoW;

    logic [RecW-1:0] r_mem [TableDepth];
    logic [RecW-1:0] r_rd;
    logic [AddrW-1:0] rd_addr;

    t_state r_st, n_st;
    t_cmd r_cmd;
    logic [CountW-1:0] r_count, r_lo, r_hi;
    logic [DayW-1:0] r_last;
    logic [RecW-1:0] r_a, r_b;
    logic [DayW-1:0] r_rem, r_den;
    logic [FracBits:0] r_t;
    logic [5:0] r_it;
    logic [2:0] r_k;
    logic [2:0] r_status;
    logic [DayW-1:0] r_oday;
    logic [NumVals*ValW-1:0] r_ovals;
    logic r_opred;
    logic [LoW+FracBits:0] r_pl;
    logic [HiW+FracBits:0] r_ph;
    logic r_neg;

    logic is_query, mem_we;
    logic [CountW-1:0] mid;
    logic [DayW-1:0] a_day, b_day, rd_day, rem2;
    logic [DayW:0] rem_sh;
    t_val va, vb;
    logic signed [ValW:0] delta;
    logic [MagW-1:0] mag;
    logic [MagW+FracBits:0] rounded;
    logic [ValW:0] rmag;
    t_val sum;

    assign is_query = (r_cmd.mode == M_NEAREST) || (r_cmd.mode == M_INTERP)
        || (r_cmd.mode == M_RESOLVE);
    assign mid = r_lo + ((r_hi - r_lo) >> 1);
    assign rd_day = r_rd[RecW-1 -: DayW];
    assign a_day = r_a[RecW-1 -: DayW];
    assign b_day = r_b[RecW-1 -: DayW];
    assign mem_we = (r_st == S_DECIDE) && (r_cmd.mode == M_APPEND)
        && (r_count != CountW'(TableDepth))
        && !(r_count != '0 && r_cmd.day < r_last);
    assign o_take = (r_st == S_IDLE);
    assign o_valid = (r_st == S_OUT);
    assign o_status = r_status;
    assign o_day = r_oday;
    assign o_vals = r_ovals;
    assign o_pred = r_opred;

    assign rem_sh = {r_rem, 1'b0};
    assign rem2 = (rem_sh >= {1'b0, r_den}) ? DayW'(rem_sh - {1'b0, r_den})
        : DayW'(rem_sh);
    assign va = r_a[1 + (NumVals-1-r_k)*ValW +: ValW];
    assign vb = r_b[1 + (NumVals-1-r_k)*ValW +: ValW];
    assign delta = (ValW+1)'(vb) - (ValW+1)'(va);
    assign mag = delta[ValW] ? MagW'(-delta) : MagW'(delta);
    assign rounded = (MagW+FracBits+1)'(r_pl) + ((MagW+FracBits+1)'(r_ph) << LoW)
        + ((MagW+FracBits+1)'(1) << (FracBits-1));
    assign rmag = rounded[FracBits +: ValW+1];
    assign sum = ValW'((ValW+1)'(va) + (r_neg ? -rmag : rmag));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_count[AddrW-1:0]] <= {r_cmd.day, r_cmd.vals, r_cmd.pred};
        end
        r_rd <= r_mem[rd_addr];
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (i_valid) n_st = S_DECIDE;
            S_DECIDE: begin
                if (!is_query || r_count == '0) n_st = S_OUT;
                else n_st = S_SEARCH;
            end
            S_SEARCH: n_st = (r_lo < r_hi) ? S_SWAIT : S_READA;
            S_SWAIT: n_st = S_SEARCH;
            S_READA: n_st = S_READB;
            S_READB: n_st = S_WAITB;
            S_WAITB: n_st = S_PICK;
            S_PICK: begin
                if (r_cmd.mode == M_NEAREST || r_lo == '0 || r_lo >= r_count
                        || b_day <= a_day) n_st = S_OUT;
                else n_st = S_DIV;
            end
            S_DIV: n_st = (r_it != 6'd0) ? S_DIV : S_MUL;
            S_MUL: n_st = S_MULW;
            S_MULW: n_st = (r_k != 3'(NumVals-1)) ? S_MUL : S_OUT;
            S_OUT: if (!i_stall) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_comb begin
        rd_addr = mid[AddrW-1:0];
        if (r_st == S_READA || r_st == S_SEARCH && !(r_lo < r_hi)) begin
            rd_addr = (r_lo == '0) ? '0 : AddrW'(r_lo - 1'b1);
        end
        if (r_st == S_READA) begin
            rd_addr = (r_lo >= r_count) ? AddrW'(r_count - 1'b1) : r_lo[AddrW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_count <= '0;
        end else begin
            r_st <= n_st;
            if (r_st == S_DECIDE && r_cmd.mode == M_CLEAR) r_count <= '0;
            if (mem_we) r_count <= r_count + 1'b1;
        end
        if (mem_we) r_last <= r_cmd.day;
        unique case (r_st)
            S_IDLE: begin
                r_cmd <= i_cmd;
                r_lo <= '0;
            end
            S_DECIDE: begin
                r_hi <= r_count;
                r_oday <= '0;
                r_ovals <= '0;
                r_opred <= 1'b0;
                if (r_cmd.mode == M_APPEND && r_count == CountW'(TableDepth)) begin
                    r_status <= ST_FULL;
                end else if (r_cmd.mode == M_APPEND && !mem_we) begin
                    r_status <= ST_ORDER;
                end else if (is_query && r_count == '0) begin
                    r_status <= ST_EMPTY;
                end else begin
                    r_status <= ST_OK;
                end
            end
            S_SWAIT: begin
                if (rd_day < r_cmd.day) r_lo <= mid + 1'b1;
                else r_hi <= mid;
            end
            S_READA: r_a <= r_rd;
            S_READB: r_b <= r_rd;
            S_PICK: begin
                r_rem <= r_cmd.day - a_day;
                r_den <= b_day - a_day;
                r_t <= '0;
                r_it <= 6'(FracBits);
                r_k <= '0;
                if (r_cmd.mode == M_RESOLVE && (r_lo == '0 && r_cmd.day < b_day
                        || r_lo >= r_count)) begin
                    r_status <= ST_RANGE;
                    {r_oday, r_ovals, r_opred} <= '0;
                end else if (r_lo == '0 || r_lo >= r_count) begin
                    {r_oday, r_ovals, r_opred} <= r_b;
                end else if (r_cmd.mode == M_NEAREST) begin
                    if (r_cmd.day - a_day <= b_day - r_cmd.day)
                        {r_oday, r_ovals, r_opred} <= r_a;
                    else
                        {r_oday, r_ovals, r_opred} <= r_b;
                end else if (b_day <= a_day) begin
                    {r_oday, r_ovals, r_opred} <= r_a;
                end
            end
            S_DIV: begin
                if (r_it == 6'(FracBits) && r_rem >= r_den) begin
                    r_t <= (FracBits+1)'(1) << FracBits;
                    r_it <= 6'd0;
                end else if (r_it != 6'd0) begin
                    r_rem <= rem2;
                    r_t <= {r_t[FracBits-1:0], rem_sh >= {1'b0, r_den}};
                    r_it <= r_it - 1'b1;
                end
                r_oday <= r_cmd.day;
                r_opred <= r_a[0] | r_b[0];
            end
            S_MUL: begin
                r_pl <= (LoW+FracBits+1)'(mag[LoW-1:0]) * (LoW+FracBits+1)'(r_t);
                r_ph <= (HiW+FracBits+1)'(mag[MagW-1:LoW]) * (HiW+FracBits+1)'(r_t);
                r_neg <= delta[ValW];
            end
            S_MULW: begin
                r_ovals[(NumVals-1-r_k)*ValW +: ValW] <= sum;
                r_k <= r_k + 1'b1;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ===== sv/sorted_table_interpolator_unit.sv =====
// Nearest and interpolation begin with a binary search of the table; interpolation
// then runs a serial divider and one multiply per value.
// Throughput: one request at a time in the back end, which takes the next one in
// the cycle after a result is accepted; a two-entry queue lets the front accept two more.
// Reset is synchronous, active low, and empties the table and the queue.
`default_nettype none
module sorted_table_interpolator_unit
    import sti_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic o_stall,
    input  wire logic [2:0] i_mode,
    input  wire logic [48:0] i_day,
    input  wire logic signed [35:0] i_pole_x,
    input  wire logic signed [35:0] i_pole_y,
    input  wire logic signed [35:0] i_ut1_offset,
    input  wire logic signed [35:0] i_day_length_excess,
    input  wire logic signed [35:0] i_nutation_dx,
    input  wire logic signed [35:0] i_nutation_dy,
    input  wire logic i_is_predicted,
    output logic o_valid,
    input  wire logic i_stall,
    output logic [2:0] o_status,
    output logic [48:0] o_out_day,
    output logic signed [35:0] o_out_pole_x,
    output logic signed [35:0] o_out_pole_y,
    output logic signed [35:0] o_out_ut1_offset,
    output logic signed [35:0] o_out_day_length,
    output logic signed [35:0] o_out_dx,
    output logic signed [35:0] o_out_dy,
    output logic o_out_predicted
);
    t_cmd in_cmd, q_cmd;
    logic q_valid, q_take;
    logic [NumVals*ValW-1:0] vals;

    assign in_cmd = '{mode: i_mode, day: i_day,
        vals: {i_pole_x, i_pole_y, i_ut1_offset, i_day_length_excess,
               i_nutation_dx, i_nutation_dy},
        pred: i_is_predicted};

    sti_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_cmd(in_cmd),
        .o_valid(q_valid), .i_take(q_take), .o_cmd(q_cmd)
    );

    sti_back u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .o_take(q_take), .i_cmd(q_cmd),
        .o_valid, .i_stall, .o_status, .o_day(o_out_day), .o_vals(vals),
        .o_pred(o_out_predicted)
    );

    assign {o_out_pole_x, o_out_pole_y, o_out_ut1_offset, o_out_day_length,
            o_out_dx, o_out_dy} = vals;
endmodule
`default_nettype wire

// ===== sv/sti_checker.sv =====
`default_nettype none
module sti_checker
    import sti_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_valid,
    input wire logic i_stall,
    input wire logic [2:0] o_status,
    input wire logic [48:0] o_out_day
);
    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= 3'(ST_ORDER))
        else $error("illegal status");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_out_day))
        else $error("stalled result changed");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != 3'(ST_OK) |-> o_out_day == '0)
        else $error("error result carries data");
endmodule

bind sorted_table_interpolator_unit sti_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_status, .o_out_day
);
`default_nettype wire

// ===== test/sorted_table_interpolator_unit_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module sorted_table_interpolator_unit_tb;
    import sti_pkg::*;

    typedef struct {
        logic [2:0] mode;
        logic [DayW-1:0] day;
        logic signed [ValW-1:0] vals [NumVals];
        logic pred;
    } t_request;

    typedef struct {
        logic [2:0] status;
        logic [DayW-1:0] day;
        logic signed [ValW-1:0] vals [NumVals];
        logic pred;
    } t_answer;

    typedef struct {
        logic [2:0] mode;
        logic [DayW-1:0] day;
        logic signed [ValW-1:0] v0;
        logic pred;
        logic known;
        logic [2:0] status;
        logic [DayW-1:0] out_day;
        logic signed [ValW-1:0] out_v0;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [2:0] i_mode = '0;
    logic [48:0] i_day = '0;
    logic signed [35:0] i_vals [NumVals];
    logic i_is_predicted = 1'b0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [2:0] o_status;
    logic [48:0] o_out_day;
    logic signed [35:0] o_vals [NumVals];
    logic o_out_predicted;

    int error_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    int table_count;
    logic [DayW-1:0] table_day [TableDepth];
    logic signed [ValW-1:0] table_val [TableDepth][NumVals];
    logic table_pred [TableDepth];

    t_answer pending_answers [$];
    t_answer pinned_answers [$];
    bit pinned_flags [$];

    initial for (int k = 0; k < NumVals; k++) i_vals[k] = '0;

    always #4 i_clk = ~i_clk;

    sorted_table_interpolator_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_mode(i_mode), .i_day(i_day),
        .i_pole_x(i_vals[0]), .i_pole_y(i_vals[1]), .i_ut1_offset(i_vals[2]),
        .i_day_length_excess(i_vals[3]), .i_nutation_dx(i_vals[4]),
        .i_nutation_dy(i_vals[5]), .i_is_predicted(i_is_predicted),
        .o_valid(o_valid), .i_stall(i_stall), .o_status(o_status),
        .o_out_day(o_out_day),
        .o_out_pole_x(o_vals[0]), .o_out_pole_y(o_vals[1]),
        .o_out_ut1_offset(o_vals[2]), .o_out_day_length(o_vals[3]),
        .o_out_dx(o_vals[4]), .o_out_dy(o_vals[5]),
        .o_out_predicted(o_out_predicted)
    );

    function automatic t_answer blank_answer(logic [2:0] status);
        t_answer a;
        a.status = status;
        a.day = '0;
        a.pred = 1'b0;
        for (int k = 0; k < NumVals; k++) a.vals[k] = '0;
        return a;
    endfunction

    function automatic t_answer record_answer(int idx);
        t_answer a;
        a.status = ST_OK;
        a.day = table_day[idx];
        a.pred = table_pred[idx];
        for (int k = 0; k < NumVals; k++) a.vals[k] = table_val[idx][k];
        return a;
    endfunction

    function automatic int first_not_below(logic [DayW-1:0] day);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = table_count;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (table_day[mid] < day) lo = mid + 1;
            else hi = mid;
        end
        return lo;
    endfunction

    function automatic t_answer blend_records(logic [DayW-1:0] day);
        t_answer a;
        int hi_idx;
        int lo_idx;
        logic [FracBits:0] weight;
        logic [DayW+FracBits:0] ratio;
        logic signed [ValW:0] delta;
        logic [ValW+FracBits+1:0] mag;
        logic [ValW+1:0] step;
        hi_idx = first_not_below(day);
        if (hi_idx == 0) return record_answer(0);
        if (hi_idx >= table_count) return record_answer(table_count - 1);
        lo_idx = hi_idx - 1;
        if (table_day[hi_idx] <= table_day[lo_idx]) return record_answer(lo_idx);
        ratio = ({{(FracBits+1){1'b0}}, day - table_day[lo_idx]} << FracBits)
                / (table_day[hi_idx] - table_day[lo_idx]);
        weight = ratio[FracBits:0];
        a.status = ST_OK;
        a.day = day;
        a.pred = table_pred[lo_idx] | table_pred[hi_idx];
        for (int k = 0; k < NumVals; k++) begin
            delta = $signed({table_val[hi_idx][k][ValW-1], table_val[hi_idx][k]})
                  - $signed({table_val[lo_idx][k][ValW-1], table_val[lo_idx][k]});
            mag = (delta < 0) ? (ValW+FracBits+2)'(-delta) : (ValW+FracBits+2)'(delta);
            mag = mag * weight + (1 << (FracBits - 1));
            step = mag[ValW+FracBits+1:FracBits];
            a.vals[k] = (delta < 0) ? table_val[lo_idx][k] - ValW'(step)
                                    : table_val[lo_idx][k] + ValW'(step);
        end
        return a;
    endfunction

    function automatic t_answer apply_request(t_request r);
        int idx;
        case (r.mode)
            M_CLEAR: begin
                table_count = 0;
                return blank_answer(ST_OK);
            end
            M_APPEND: begin
                if (table_count >= TableDepth) return blank_answer(ST_FULL);
                if (table_count > 0 && r.day < table_day[table_count - 1])
                    return blank_answer(ST_ORDER);
                table_day[table_count] = r.day;
                for (int k = 0; k < NumVals; k++) table_val[table_count][k] = r.vals[k];
                table_pred[table_count] = r.pred;
                table_count++;
                return blank_answer(ST_OK);
            end
            M_NEAREST: begin
                if (table_count == 0) return blank_answer(ST_EMPTY);
                idx = first_not_below(r.day);
                if (idx == 0) return record_answer(0);
                if (idx >= table_count) return record_answer(table_count - 1);
                if (r.day - table_day[idx - 1] <= table_day[idx] - r.day)
                    return record_answer(idx - 1);
                return record_answer(idx);
            end
            M_INTERP: begin
                if (table_count == 0) return blank_answer(ST_EMPTY);
                return blend_records(r.day);
            end
            M_RESOLVE: begin
                if (table_count == 0) return blank_answer(ST_EMPTY);
                if (r.day < table_day[0] || r.day > table_day[table_count - 1])
                    return blank_answer(ST_RANGE);
                return blend_records(r.day);
            end
            default: return blank_answer(ST_OK);
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("Mismatch at %0t: %s got %h, expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic send_request(t_request r, bit known, t_answer pinned);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= r.mode;
        i_day <= r.day;
        for (int k = 0; k < NumVals; k++) i_vals[k] <= r.vals[k];
        i_is_predicted <= r.pred;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_answers.insert(pending_answers.size(), apply_request(r));
        pinned_flags.insert(pinned_flags.size(), known);
        pinned_answers.insert(pinned_answers.size(), pinned);
    endtask

    task automatic send_plain(t_request r);
        send_request(r, 1'b0, blank_answer(ST_OK));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_answer want;
        t_answer pin;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected result", o_status, '0);
            end else begin
                want = pending_answers.pop_front();
                pin = pinned_answers.pop_front();
                if (pinned_flags.pop_front()) begin
                    if (pin.status != want.status || pin.day != want.day
                            || pin.vals[0] != want.vals[0])
                        report_mismatch("table row", {pin.status, pin.day}, {want.status, want.day});
                end
                if (o_status != want.status) report_mismatch("status", o_status, want.status);
                if (o_out_day != want.day) report_mismatch("out_day", o_out_day, want.day);
                for (int k = 0; k < NumVals; k++)
                    if (o_vals[k] !== want.vals[k])
                        report_mismatch($sformatf("value %0d", k), o_vals[k], want.vals[k]);
                if (o_out_predicted !== want.pred)
                    report_mismatch("out_predicted", o_out_predicted, want.pred);
            end
        end
    end

    function automatic t_request random_request(logic [2:0] mode, logic [DayW-1:0] day);
        t_request r;
        r.mode = mode;
        r.day = day;
        for (int k = 0; k < NumVals; k++) r.vals[k] = ValW'({$urandom(), $urandom()});
        r.pred = 1'($urandom_range(1));
        return r;
    endfunction

    function automatic logic [DayW-1:0] random_day();
        return DayW'({$urandom(), $urandom()});
    endfunction

    localparam logic [DayW-1:0] DayMax = {DayW{1'b1}};
    localparam logic signed [ValW-1:0] ValMin = {1'b1, {(ValW-1){1'b0}}};
    localparam logic signed [ValW-1:0] ValMax = {1'b0, {(ValW-1){1'b1}}};

    t_row directed_rows [] = '{
        '{M_NEAREST, 49'd5, 0, 0, 1, ST_EMPTY, 0, 0},
        '{M_INTERP, 49'd5, 0, 0, 1, ST_EMPTY, 0, 0},
        '{M_RESOLVE, 49'd5, 0, 0, 1, ST_EMPTY, 0, 0},
        '{M_APPEND, 49'd1000, ValMin, 1'b1, 1, ST_OK, 0, 0},
        '{M_APPEND, 49'd999, 0, 0, 1, ST_ORDER, 0, 0},
        '{M_APPEND, 49'd1000, ValMax, 0, 1, ST_OK, 0, 0},
        '{M_APPEND, 49'd3000, ValMax, 0, 1, ST_OK, 0, 0},
        '{M_APPEND, DayMax, ValMin, 0, 1, ST_OK, 0, 0},
        '{M_NEAREST, 49'd0, 0, 0, 1, ST_OK, 49'd1000, ValMin},
        '{M_NEAREST, DayMax, 0, 0, 0, ST_OK, 0, 0},
        '{M_NEAREST, 49'd2000, 0, 0, 1, ST_OK, 49'd1000, ValMax},
        '{M_NEAREST, 49'd2001, 0, 0, 1, ST_OK, 49'd3000, ValMax},
        '{M_INTERP, 49'd0, 0, 0, 1, ST_OK, 49'd1000, ValMin},
        '{M_INTERP, 49'd1000, 0, 0, 1, ST_OK, 49'd1000, ValMin},
        '{M_INTERP, 49'd2000, 0, 0, 0, ST_OK, 0, 0},
        '{M_INTERP, 49'h1_0000_0000_0000, 0, 0, 0, ST_OK, 0, 0},
        '{M_RESOLVE, 49'd999, 0, 0, 1, ST_RANGE, 0, 0},
        '{M_RESOLVE, 49'd2500, 0, 0, 0, ST_OK, 0, 0},
        '{M_RESOLVE, DayMax, 0, 0, 0, ST_OK, 0, 0},
        '{3'd5, 49'd77, 0, 0, 1, ST_OK, 0, 0},
        '{3'd7, DayMax, 0, 0, 1, ST_OK, 0, 0},
        '{M_CLEAR, 49'd0, 0, 0, 1, ST_OK, 0, 0},
        '{M_RESOLVE, 49'd1000, 0, 0, 1, ST_EMPTY, 0, 0}
    };

    task automatic wait_until_drained();
        i_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic random_phase(int count);
        t_request r;
        logic [DayW-1:0] base;
        int kind;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(99);
            base = (table_count > 0) ? table_day[table_count - 1] : random_day() >> 2;
            if (kind < 45)
                r = random_request(M_APPEND, (kind < 40) ? base + $urandom_range(1 << 20)
                                                         : random_day());
            else if (kind < 88)
                r = random_request(3'(M_NEAREST + $urandom_range(2)),
                                   (kind < 80 && table_count > 0)
                                   ? table_day[$urandom_range(table_count - 1)]
                                     + $urandom_range(1 << 21) - (1 << 20)
                                   : random_day());
            else if (kind < 92) r = random_request(M_CLEAR, random_day());
            else if (kind < 95) r = random_request(3'(5 + $urandom_range(2)), random_day());
            else r = random_request(M_APPEND, DayMax);
            send_plain(r);
        end
    endtask

    initial begin
        t_request r;
        t_answer pin;
        table_count = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 6;
        recv_idle_pct = 82;
        foreach (directed_rows[n]) begin
            r.mode = directed_rows[n].mode;
            r.day = directed_rows[n].day;
            for (int k = 0; k < NumVals; k++) r.vals[k] = directed_rows[n].v0 + k;
            r.pred = directed_rows[n].pred;
            pin = blank_answer(directed_rows[n].status);
            pin.day = directed_rows[n].out_day;
            pin.vals[0] = directed_rows[n].out_v0;
            if (directed_rows[n].known && directed_rows[n].mode != M_APPEND
                    && directed_rows[n].status == ST_OK && directed_rows[n].out_day != 0)
                send_request(r, 1'b1, pin);
            else if (directed_rows[n].known && directed_rows[n].out_day == 0)
                send_request(r, 1'b1, pin);
            else
                send_plain(r);
        end

        wait_until_drained();
        random_phase(180);
        wait_until_drained();
        send_idle_pct = 82;
        recv_idle_pct = 6;
        random_phase(180);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(167);

        wait_until_drained();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("Timeout at %0t", $realtime);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
